// File: rtl/wcp_pkg.sv
// shared types, tags and codes for the riff/wave chunk header parser
package wcp_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned WordW    = 32;
    localparam int unsigned StatusW  = 3;
    localparam int unsigned OutDataW = 72;

    localparam logic [WordW-1:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [WordW-1:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [WordW-1:0] TAG_FACT = 32'h7463_6166;
    localparam logic [WordW-1:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [WordW-1:0] TAG_DATA = 32'h6174_6164;

    typedef enum logic [2:0] {
        PH_RIFF_TAG,
        PH_RIFF_LEN,
        PH_WAVE_TAG,
        PH_CHUNK_TAG,
        PH_CHUNK_LEN,
        PH_SKIP
    } phase_t;

    typedef enum logic [StatusW-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_RIFF  = 3'd1,
        ST_NOT_WAVE  = 3'd2,
        ST_COMPRESS  = 3'd3,
        ST_NO_DATA   = 3'd4,
        ST_TRUNCATED = 3'd5
    } status_t;

    typedef struct packed {
        logic             last_of_buffer;
        logic             first_of_file;
        logic [ByteW-1:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [WordW-1:0] data_offset;
        logic [WordW-1:0] data_length;
        status_t          status;
    } result_t;

endpackage

// File: rtl/wav_chunk_header_parser_top.sv
// top level of the riff/wave chunk header parser
// Takes a RIFF/WAVE file one byte per word and gives at most one result word per file: the data
// chunk's length and offset, or an error code. A byte is accepted every cycle unless the input
// register is full and a result word waits on m_tready; each byte is handled in one pass between
// the input register and the result register, so a result word is loaded into the result register
// as the byte that caused it leaves the input register. While a result word waits on m_tready no
// further byte is parsed, whether or not it would give a result, so the input stalls once its register is full.
module wav_chunk_header_parser_top
    import wcp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ByteW-1:0]    s_tdata,   // byte_value
    input  logic [0:0]          s_tuser,   // first_of_file
    input  logic                s_tlast,   // last_of_buffer
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata    // status, data_length, data_offset, zero pad
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     out_free;
    logic     step;
    logic     has_result;
    result_t  result;

    assign s_item = '{last_of_buffer: s_tlast, first_of_file: s_tuser[0], byte_value: s_tdata};
    assign step   = item_valid && out_free;

    wcp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    wcp_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    wcp_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (has_result),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/wcp_in_stage.sv
// input register stage holding one accepted byte word
module wcp_in_stage
    import wcp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign s_ready    = !valid_reg || take;
    assign accept     = s_valid && s_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: rtl/wcp_parse.sv
// chunk walk state and per-byte parse logic
module wcp_parse
    import wcp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  in_item_t item,
    output logic     has_result,
    output result_t  result
);

    phase_t           phase_reg, phase_next;
    logic [WordW-1:0] field_shift_reg, field_shift_next;
    logic [1:0]       field_cnt_reg, field_cnt_next;
    logic [WordW-1:0] body_end_reg, body_end_next;
    logic [WordW-1:0] body_pos_reg, body_pos_next;
    logic [WordW-1:0] file_pos_reg, file_pos_next;
    logic [WordW:0]   skip_reg, skip_next;
    logic [WordW-1:0] chunk_tag_reg, chunk_tag_next;
    logic             finished_reg, finished_next;

    // values after an optional restart on first_of_file
    phase_t           ph;
    logic [WordW-1:0] fs, be, bp, fp, ctag;
    logic [1:0]       cnt;
    logic [WordW:0]   skip;
    logic             fin;

    logic [WordW-1:0]   fs_new;
    logic [1:0]         cnt_new;
    logic [WordW:0]     skip_dec;
    logic [WordW:0]     skip_len;
    logic [WordW+1:0]   bp_sum;
    logic [WordW-1:0]   bp_sat;
    logic               st_valid;
    status_t            st;

    always_comb begin
        fin  = item.first_of_file ? 1'b0 : finished_reg;
        ph   = item.first_of_file ? PH_RIFF_TAG : phase_reg;
        fs   = item.first_of_file ? '0 : field_shift_reg;
        cnt  = item.first_of_file ? '0 : field_cnt_reg;
        be   = item.first_of_file ? '0 : body_end_reg;
        bp   = item.first_of_file ? '0 : body_pos_reg;
        fp   = item.first_of_file ? '0 : file_pos_reg;
        skip = item.first_of_file ? '0 : skip_reg;
        ctag = item.first_of_file ? '0 : chunk_tag_reg;
    end

    always_comb begin
        fs_new   = {item.byte_value, fs[WordW-1:ByteW]};
        cnt_new  = cnt + 2'd1;
        skip_dec = (skip != '0) ? skip - 1'b1 : skip;
        skip_len = {1'b0, fs_new} + {{WordW{1'b0}}, fs_new[0]};
        bp_sum   = {2'b00, bp} + (WordW+2)'(8) + {1'b0, skip_len};
        bp_sat   = (bp_sum[WordW+1:WordW] != 2'b00) ? '1 : bp_sum[WordW-1:0];
    end

    always_comb begin
        phase_next       = phase_reg;
        field_shift_next = field_shift_reg;
        field_cnt_next   = field_cnt_reg;
        body_end_next    = body_end_reg;
        body_pos_next    = body_pos_reg;
        file_pos_next    = file_pos_reg;
        skip_next        = skip_reg;
        chunk_tag_next   = chunk_tag_reg;
        finished_next    = finished_reg;
        st_valid         = 1'b0;
        st               = ST_TRUNCATED;
        result           = '{data_offset: '0, data_length: '0, status: ST_TRUNCATED};

        if (!fin) begin
            phase_next       = ph;
            field_shift_next = fs;
            field_cnt_next   = cnt;
            body_end_next    = be;
            body_pos_next    = bp;
            skip_next        = skip;
            chunk_tag_next   = ctag;
            finished_next    = fin;
            file_pos_next    = fp + 1'b1;

            if (ph == PH_SKIP) begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    if (bp >= be) begin
                        st_valid = 1'b1;
                        st       = ST_NO_DATA;
                    end else begin
                        phase_next = PH_CHUNK_TAG;
                    end
                end
            end else begin
                field_shift_next = fs_new;
                field_cnt_next   = cnt_new;
                if (cnt_new == 2'd0) begin
                    case (ph)
                        PH_RIFF_TAG: begin
                            if (fs_new != TAG_RIFF) begin
                                st_valid = 1'b1;
                                st       = ST_NOT_RIFF;
                            end else begin
                                phase_next = PH_RIFF_LEN;
                            end
                        end
                        PH_RIFF_LEN: begin
                            body_end_next = (fs_new >= WordW'(4)) ? fs_new - WordW'(4) : '0;
                            phase_next    = PH_WAVE_TAG;
                        end
                        PH_WAVE_TAG: begin
                            if (fs_new != TAG_WAVE) begin
                                st_valid = 1'b1;
                                st       = ST_NOT_WAVE;
                            end else if (bp >= be) begin
                                st_valid = 1'b1;
                                st       = ST_NO_DATA;
                            end else begin
                                phase_next = PH_CHUNK_TAG;
                            end
                        end
                        PH_CHUNK_TAG: begin
                            chunk_tag_next = fs_new;
                            phase_next     = PH_CHUNK_LEN;
                        end
                        PH_CHUNK_LEN: begin
                            if (ctag == TAG_DATA) begin
                                st_valid           = 1'b1;
                                st                 = ST_FOUND;
                                result.data_length = fs_new;
                                result.data_offset = fp + 1'b1;
                            end else if (ctag == TAG_FACT) begin
                                st_valid = 1'b1;
                                st       = ST_COMPRESS;
                            end else begin
                                // fmt and unknown chunks: skip body plus pad
                                skip_next     = skip_len;
                                body_pos_next = bp_sat;
                                if (skip_len == '0) begin
                                    if (bp_sat >= be) begin
                                        st_valid = 1'b1;
                                        st       = ST_NO_DATA;
                                    end else begin
                                        phase_next = PH_CHUNK_TAG;
                                    end
                                end else begin
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                        default: begin
                            st_valid = 1'b1;
                            st       = ST_TRUNCATED;
                        end
                    endcase
                end
            end

            if (!st_valid && item.last_of_buffer) begin
                st_valid = 1'b1;
                st       = ST_TRUNCATED;
            end
            if (st_valid) begin
                finished_next = 1'b1;
            end
        end
        result.status = st;
        has_result    = step && st_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_RIFF_TAG;
            field_shift_reg <= '0;
            field_cnt_reg   <= '0;
            body_end_reg    <= '0;
            body_pos_reg    <= '0;
            file_pos_reg    <= '0;
            skip_reg        <= '0;
            chunk_tag_reg   <= '0;
            finished_reg    <= 1'b1;
        end else if (step) begin
            phase_reg       <= phase_next;
            field_shift_reg <= field_shift_next;
            field_cnt_reg   <= field_cnt_next;
            body_end_reg    <= body_end_next;
            body_pos_reg    <= body_pos_next;
            file_pos_reg    <= file_pos_next;
            skip_reg        <= skip_next;
            chunk_tag_reg   <= chunk_tag_next;
            finished_reg    <= finished_next;
        end
    end

endmodule

// File: rtl/wcp_out_stage.sv
// result register on the master side
module wcp_out_stage
    import wcp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  result_t             result,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, data_reg};

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

// File: rtl/wcp_checker.sv
// port-level checks for the riff/wave chunk header parser
module wcp_checker
    import wcp_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= 3'd5))
        else $error("status code out of range");

    // error results carry no length or offset
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != 3'd0) |-> (m_tdata[66:3] == '0))
        else $error("error result with non-zero length or offset");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word after reset");

endmodule

bind wav_chunk_header_parser_top wcp_checker u_checker (.*);

// File: bench/wav_chunk_header_parser_top_test.sv
// testbench for the riff/wave chunk header parser: whole, broken and noisy files checked per result
module wav_chunk_header_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wcp_pkg::*;

    localparam int          TargetBytes   = 1400;
    localparam int          MinFiles      = 40;
    localparam int          CalmTail      = 200;
    localparam int          HoldStart     = 300;
    localparam int          HoldCycles    = 400;
    localparam int          WatchdogLimit = 2000;
    localparam int          SettleCycles  = 12;
    localparam int unsigned ResultW       = $bits(result_t);
    localparam logic [31:0] TagList       = 32'h5453_494C;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [ByteW-1:0]    s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;

    wav_chunk_header_parser_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    in_item_t   byte_queue[$];
    result_t    pending_results[$];
    logic [7:0] file_bytes[$];
    in_item_t   next_word;
    result_t    got_word;
    result_t    want_word;

    int   file_bytes_sent = 0;
    int   files_made      = 0;
    int   bytes_taken     = 0;
    int   mismatches      = 0;
    int   stall_cycles    = 0;
    int   send_gap        = 0;
    int   recv_gap        = 0;
    int   hold_left       = 0;
    logic hold_done       = 1'b0;
    logic hold_active;
    logic send_lazy       = 1'b1;
    logic recv_lazy       = 1'b1;

    assign hold_active = (hold_left != 0);

    // parser state mirrored from the block
    phase_t      wp_phase    = PH_RIFF_TAG;
    logic [31:0] wp_shift    = '0;
    logic [1:0]  wp_count    = '0;
    logic [31:0] wp_body_end = '0;
    logic [31:0] wp_body_pos = '0;
    logic [31:0] wp_file_pos = '0;
    logic [32:0] wp_skip     = '0;
    logic [31:0] wp_tag      = '0;
    logic        wp_idle     = 1'b1;

    initial forever #6 aclk = ~aclk;

    function automatic void restart_parse();
        wp_phase    = PH_RIFF_TAG;
        wp_shift    = '0;
        wp_count    = '0;
        wp_body_end = '0;
        wp_body_pos = '0;
        wp_file_pos = '0;
        wp_skip     = '0;
        wp_tag      = '0;
    endfunction

    function automatic void advance_walk(input logic [32:0] amount);
        logic [33:0] total;
        total = {2'b00, wp_body_pos} + {1'b0, amount};
        wp_body_pos = (total > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    // end of the chunk walk, otherwise on to the next chunk header
    function automatic logic walk_over();
        if (wp_body_pos >= wp_body_end) return 1'b1;
        wp_phase = PH_CHUNK_TAG;
        return 1'b0;
    endfunction

    function automatic void parse_byte(input in_item_t it);
        logic        done;
        status_t     st;
        result_t     res;
        logic [31:0] v;
        done = 1'b0;
        st   = ST_FOUND;
        res  = '0;
        if (it.first_of_file) begin
            restart_parse();
            wp_idle = 1'b0;
        end
        if (wp_idle) return;
        wp_file_pos = wp_file_pos + 32'd1;
        if (wp_phase == PH_SKIP) begin
            if (wp_skip != 0) wp_skip = wp_skip - 33'd1;
            if (wp_skip == 0 && walk_over()) begin
                done = 1'b1;
                st   = ST_NO_DATA;
            end
        end else begin
            wp_shift = {it.byte_value, wp_shift[31:8]};
            wp_count = wp_count + 2'd1;
            if (wp_count == 2'd0) begin
                v = wp_shift;
                case (wp_phase)
                    PH_RIFF_TAG: begin
                        if (v != TAG_RIFF) begin
                            done = 1'b1;
                            st   = ST_NOT_RIFF;
                        end else begin
                            wp_phase = PH_RIFF_LEN;
                        end
                    end
                    PH_RIFF_LEN: begin
                        wp_body_end = (v >= 32'd4) ? v - 32'd4 : 32'd0;
                        wp_phase    = PH_WAVE_TAG;
                    end
                    PH_WAVE_TAG: begin
                        if (v != TAG_WAVE) begin
                            done = 1'b1;
                            st   = ST_NOT_WAVE;
                        end else if (walk_over()) begin
                            done = 1'b1;
                            st   = ST_NO_DATA;
                        end
                    end
                    PH_CHUNK_TAG: begin
                        wp_tag   = v;
                        wp_phase = PH_CHUNK_LEN;
                    end
                    PH_CHUNK_LEN: begin
                        advance_walk(33'd8);
                        if (wp_tag == TAG_DATA) begin
                            done            = 1'b1;
                            st              = ST_FOUND;
                            res.data_length = v;
                            res.data_offset = wp_file_pos;
                        end else if (wp_tag == TAG_FACT) begin
                            done = 1'b1;
                            st   = ST_COMPRESS;
                        end else begin
                            wp_skip = {1'b0, v} + v[0];
                            advance_walk(wp_skip);
                            if (wp_skip != 0) begin
                                wp_phase = PH_SKIP;
                            end else if (walk_over()) begin
                                done = 1'b1;
                                st   = ST_NO_DATA;
                            end
                        end
                    end
                    default: begin
                        done = 1'b1;
                        st   = ST_TRUNCATED;
                    end
                endcase
            end
        end
        if (!done && it.last_of_buffer) begin
            done = 1'b1;
            st   = ST_TRUNCATED;
        end
        if (done) begin
            wp_idle    = 1'b1;
            res.status = st;
            pending_results.push_back(res);
        end
    endfunction

    function automatic void add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
    endfunction

    function automatic void add_random(input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void push_loose(input logic [7:0] b, input logic is_last);
        in_item_t it;
        it.byte_value     = b;
        it.first_of_file  = 1'b0;
        it.last_of_buffer = is_last;
        byte_queue.push_back(it);
    endfunction

    function automatic void send_file(input int stop, input int last_idx);
        in_item_t it;
        for (int i = 0; i < stop; i++) begin
            it.byte_value     = file_bytes[i];
            it.first_of_file  = (i == 0);
            it.last_of_buffer = (i == last_idx);
            byte_queue.push_back(it);
        end
        file_bytes_sent += stop;
        file_bytes.delete();
    endfunction

    // RIFF/WAVE file with random chunks and a possibly wrong RIFF length; returns the index of a forced last byte or -1
    function automatic int build_wave();
        logic [7:0]  chunk_part[$];
        logic [31:0] riff_len;
        logic [31:0] exact;
        logic [31:0] len;
        logic [31:0] tag;
        int          n_other;
        int          pick;
        int          force_last;
        force_last = -1;
        n_other    = $urandom_range(0, 3);
        for (int c = 0; c < n_other && force_last < 0; c++) begin
            pick = $urandom_range(0, 9);
            tag  = (pick < 4) ? TAG_FMT : (pick < 6) ? TagList : 32'($urandom);
            len  = $urandom_range(0, 11);
            if (tag == TAG_FMT && $urandom_range(0, 1) == 1) len = 32'd16;
            if ($urandom_range(0, 19) == 0)
                len = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : (32'($urandom) | 32'h0100_0000);
            add_word(tag);
            add_word(len);
            if (len > 32'd64) begin
                add_random(3);
                force_last = file_bytes.size() - 1;
            end else begin
                add_random(int'(len) + int'(len[0]));
            end
        end
        if (force_last < 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                case ($urandom_range(0, 3))
                    0:       len = 32'd0;
                    1:       len = 32'hFFFF_FFFF;
                    2:       len = $urandom_range(0, 500);
                    default: len = $urandom;
                endcase
                add_word(TAG_DATA);
                add_word(len);
                add_random($urandom_range(0, 3));
            end else if (pick < 17) begin
                add_word(TAG_FACT);
                add_word(32'd4);
                add_random(4);
            end
        end
        chunk_part = file_bytes;
        file_bytes.delete();
        exact = 32'(chunk_part.size() + 4);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: riff_len = exact;
            4, 5:       riff_len = $urandom_range(0, 7);
            6, 7:       riff_len = exact + 32'($urandom_range(0, 24)) - 32'd12;
            8:          riff_len = 32'hFFFF_FFFF;
            default:    riff_len = $urandom;
        endcase
        add_word(TAG_RIFF);
        add_word(riff_len);
        add_word(TAG_WAVE);
        foreach (chunk_part[i]) file_bytes.push_back(chunk_part[i]);
        return (force_last < 0) ? -1 : force_last + 12;
    endfunction

    // stimulus and end of run
    initial begin
        int stop;
        int last_idx;
        int idx;
        push_loose(8'hFF, 1'b1);
        push_loose(8'h00, 1'b0);
        add_word(32'h5846_4952);
        send_file(4, -1);
        add_word(TAG_RIFF);
        send_file(1, 0);
        add_word(TAG_RIFF);
        add_word(32'd3);
        add_word(TAG_WAVE);
        send_file(12, -1);
        add_word(TAG_RIFF);
        add_word(32'hFFFF_FFFF);
        add_word(32'h0000_0000);
        send_file(12, -1);

        while (file_bytes_sent < TargetBytes || files_made < MinFiles) begin
            if ($urandom_range(0, 9) == 0) begin
                add_random($urandom_range(1, 12));
                send_file(file_bytes.size(), $urandom_range(0, 15));
            end else begin
                last_idx = build_wave();
                stop     = file_bytes.size();
                if (last_idx < 0) begin
                    case ($urandom_range(0, 15))
                        0, 1: last_idx = $urandom_range(0, stop - 1);
                        2:    stop = $urandom_range(1, stop);
                        3, 4: begin
                            idx = $urandom_range(0, 11);
                            file_bytes[idx] = file_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
                        end
                        default: ;
                    endcase
                end
                send_file(stop, last_idx);
            end
            files_made++;
            repeat ($urandom_range(0, 2)) push_loose(8'($urandom), 1'($urandom));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        do @(negedge aclk);
        while (byte_queue.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (SettleCycles) @(negedge aclk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // byte driver, prediction on every accepted word
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if ($urandom_range(0, 49) == 0) send_lazy <= !send_lazy;
            if (s_tvalid && s_tready) begin
                parse_byte({s_tlast, s_tuser[0], s_tdata});
                bytes_taken <= bytes_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (send_lazy && !hold_active && byte_queue.size() >= CalmTail
                             && $urandom_range(0, 4) == 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= $urandom_range(0, 5);
                end else if (byte_queue.size() != 0) begin
                    next_word = byte_queue.pop_front();
                    s_tdata  <= next_word.byte_value;
                    s_tuser  <= next_word.first_of_file;
                    s_tlast  <= next_word.last_of_buffer;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long hold-off on the result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && bytes_taken >= HoldStart) begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if ($urandom_range(0, 49) == 0) recv_lazy <= !recv_lazy;
            if (hold_active) begin
                m_tready <= 1'b0;
            end else if (recv_gap != 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else if (recv_lazy && byte_queue.size() >= CalmTail
                         && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                recv_gap <= $urandom_range(0, 5);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_word = m_tdata[ResultW-1:0];
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending: status %0d length %0d offset %0d",
                       got_word.status, got_word.data_length, got_word.data_offset);
                mismatches++;
            end else begin
                want_word = pending_results.pop_front();
                if (got_word.status !== want_word.status) begin
                    $error("status: expected %0d, got %0d", want_word.status, got_word.status);
                    mismatches++;
                end
                if (got_word.data_length !== want_word.data_length) begin
                    $error("data_length: expected %0d, got %0d",
                           want_word.data_length, got_word.data_length);
                    mismatches++;
                end
                if (got_word.data_offset !== want_word.data_offset) begin
                    $error("data_offset: expected %0d, got %0d",
                           want_word.data_offset, got_word.data_offset);
                    mismatches++;
                end
                if (m_tdata[OutDataW-1:ResultW] !== '0) begin
                    $error("pad: expected 0, got %h", m_tdata[OutDataW-1:ResultW]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WatchdogLimit) begin
            $display("timeout: no word moved for %0d cycles", WatchdogLimit);
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

// File: sim.f
rtl/wcp_pkg.sv
rtl/wcp_in_stage.sv
rtl/wcp_parse.sv
rtl/wcp_out_stage.sv
rtl/wav_chunk_header_parser_top.sv
rtl/wcp_checker.sv
bench/wav_chunk_header_parser_top_test.sv
